// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define SWAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define SWAT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/swat_pkg.sv =====
// types and constants of the surprise window anomaly trigger
`default_nettype none
package swat_pkg;

  typedef struct packed {
    logic               func;
    logic signed [15:0] surprise;
  } swat_in_t;

  typedef struct packed {
    logic               search;
    logic               drop_flag;
    logic               spike_flag;
    logic signed [15:0] window_mean;
    logic        [15:0] window_std;
    logic signed [15:0] zscore;
    logic               stats_valid;
  } swat_out_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_GAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HISTORY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_FACTOR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSEST_GAP     = 3'd4;

  localparam logic [15:0] PERIODIC_GAP_RST    = 16'd30;
  localparam logic [7:0]  MIN_HISTORY_RST     = 8'd10;
  localparam logic [7:0]  DROP_FACTOR_RST     = 8'd128;
  localparam logic [14:0] SPIKE_THRESHOLD_RST = 15'd512;
  localparam logic [15:0] CLOSEST_GAP_RST     = 16'd20;

  localparam logic [16:0]        KF_MARGIN    = 17'd10;
  localparam logic signed [15:0] Z_DROP_LIMIT = -16'sd384;
  localparam logic signed [15:0] Z_MAX        = 16'sh7fff;
  localparam logic signed [15:0] Z_MIN        = 16'sh8000;

  localparam int MUL_W       = 33;
  localparam int QUO_W       = 32;
  localparam int VAR_Q_BITS  = 31;
  localparam int SQRT_STEPS  = 16;
  localparam int Z_DVD_BITS  = 24;

  typedef enum logic [4:0] {
    S_IDLE, S_OLD, S_NEW, S_ADD,
    S_M0, S_M1, S_M2, S_M3, S_M4,
    S_VDIV, S_SQRT, S_MDIV, S_ZSET, S_ZDIV,
    S_D1, S_D2, S_D3, S_OUT
  } swat_state_t;

endpackage
`default_nettype wire

// ===== hdl/swat_ram.sv =====
// generic single write, single read ram with registered read
`default_nettype none
module swat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/surprise_window_anomaly_trigger.sv =====
// top level: sliding window statistics, z-score and search decision
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  in_word  (func, surprise)
//  out       output     out_valid / out_stall out_word (search .. stats_valid)
//  cfg       input      cfg_write            cfg_index, cfg_data
//
// a loop event word leaves the block idle; a keyframe word with fewer than
// MIN_STATS scores skips the statistics, otherwise they run on the restoring
// divider and square root sharing one compare-subtract unit (the running
// sum is SUM_W = 16 + clog2(WINDOW+1) bits wide)
// rst is synchronous; it clears counters, sums and the output valid flag
// in_stall is high while a word is in work; a stalled result holds the
// last state until taken, while a new word may already be accepted
`default_nettype none
module surprise_window_anomaly_trigger #(
  parameter int WINDOW    = 100,
  parameter int MIN_STATS = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  swat_pkg::swat_in_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output swat_pkg::swat_out_t                out_word,
  input  logic                               cfg_write,
  input  logic [swat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swat_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import swat_pkg::*;

  localparam int PTR_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = 16 + CNT_W;
  localparam int SQ_W  = 31 + CNT_W;
  localparam int DVD_W = SQ_W + CNT_W;
  localparam int IDX_W = $clog2(DVD_W);
  localparam int DVS_W = (2 * CNT_W > 16) ? 2 * CNT_W : 16;
  localparam int RW    = DVS_W + 2;
  localparam int PRD_W = 2 * MUL_W;

  swat_state_t state, state_next;

  logic [15:0] periodic_gap, closest_gap;
  logic [7:0]  min_history, drop_factor;
  logic [14:0] spike_threshold;

  logic [PTR_W-1:0]        ptr;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         ss;
  logic [15:0]             fsl, kfc;
  logic signed [15:0]      s_reg;
  logic                    full_r;

  logic signed [PRD_W-1:0] prod;
  logic [DVD_W-1:0]        acc, dvd;
  logic [DVS_W-1:0]        dvs;
  logic [RW-1:0]           rem;
  logic [QUO_W-1:0]        quo, var_r;
  logic [IDX_W-1:0]        idx;
  logic [15:0]             root, stdv;
  logic signed [15:0]      mean_r, z_r;
  logic                    dz_neg, drop_state, spike_state, valid_r;

  logic [15:0]             ram_rdata;
  logic                    ram_we;
  logic                    full;
  logic [SUM_W-1:0]        asum;
  logic signed [16:0]      dz;
  logic [16:0]             dz_mag;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PRD_W-1:0] mul_p;
  logic [RW-1:0]           sub_a, sub_b;
  logic [RW:0]             diff;
  logic                    sub_ge;
  logic [RW-1:0]           rem_next;
  logic [QUO_W-1:0]        quo_next;
  logic [15:0]             root_next;
  logic                    hist_ok, search;

  swat_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (s_reg),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign ram_we   = (state == S_OLD);
  assign full     = (count == CNT_W'(WINDOW));
  assign asum     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign dz       = 17'(s_reg) - 17'(mean_r);
  assign dz_mag   = dz[16] ? 17'(-dz) : 17'(dz);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_OLD: begin
        mul_a = MUL_W'($signed(ram_rdata));
        mul_b = MUL_W'($signed(ram_rdata));
      end
      S_NEW: begin
        mul_a = MUL_W'(s_reg);
        mul_b = MUL_W'(s_reg);
      end
      S_M0: begin
        mul_a = MUL_W'(count);
        mul_b = MUL_W'(ss[31:0]);
      end
      S_M1: begin
        mul_a = MUL_W'(count);
        mul_b = MUL_W'(ss[SQ_W-1:32]);
      end
      S_M2: begin
        mul_a = MUL_W'(asum);
        mul_b = MUL_W'(asum);
      end
      S_M3: begin
        mul_a = MUL_W'(count);
        mul_b = MUL_W'(count);
      end
      S_D1: begin
        mul_a = MUL_W'($signed({s_reg, 8'b0}));
        mul_b = MUL_W'(count);
      end
      S_D2: begin
        mul_a = MUL_W'(sum);
        mul_b = MUL_W'(drop_factor);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // shared compare-subtract unit: one divider or square root digit a cycle
  always_comb begin
    if (state == S_SQRT) begin
      sub_a = {rem[RW-3:0], var_r[{idx[3:0], 1'b0} +: 2]};
      sub_b = RW'({root, 2'b01});
    end else begin
      sub_a = {rem[RW-2:0], dvd[idx]};
      sub_b = RW'(dvs);
    end
    diff      = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge    = !diff[RW];
    rem_next  = sub_ge ? diff[RW-1:0] : sub_a;
    quo_next  = {quo[QUO_W-2:0], sub_ge};
    root_next = {root[14:0], sub_ge};
  end

  // search decision on the finished statistics
  always_comb begin
    hist_ok = (32'(count) >= 32'(min_history));
    search  = (fsl >= periodic_gap) ||
              (hist_ok && (drop_state || (spike_state && (fsl > (periodic_gap >> 1)))));
    if (17'(kfc) < (17'(closest_gap) + KF_MARGIN)) begin
      search = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_word.func) begin
          state_next = S_OLD;
        end
      end
      S_OLD:  state_next = S_NEW;
      S_NEW:  state_next = S_ADD;
      S_ADD:  state_next = (32'(count) >= MIN_STATS) ? S_M0 : S_OUT;
      S_M0:   state_next = S_M1;
      S_M1:   state_next = S_M2;
      S_M2:   state_next = S_M3;
      S_M3:   state_next = S_M4;
      S_M4:   state_next = S_VDIV;
      S_VDIV: state_next = (idx == '0) ? S_SQRT : S_VDIV;
      S_SQRT: state_next = (idx == '0) ? S_MDIV : S_SQRT;
      S_MDIV: state_next = (idx == '0) ? S_ZSET : S_MDIV;
      S_ZSET: state_next = S_ZDIV;
      S_ZDIV: state_next = (idx == '0) ? S_D1 : S_ZDIV;
      S_D1:   state_next = S_D2;
      S_D2:   state_next = S_D3;
      S_D3:   state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_gap    <= PERIODIC_GAP_RST;
      min_history     <= MIN_HISTORY_RST;
      drop_factor     <= DROP_FACTOR_RST;
      spike_threshold <= SPIKE_THRESHOLD_RST;
      closest_gap     <= CLOSEST_GAP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PERIODIC_GAP:    periodic_gap    <= cfg_data;
        REG_MIN_HISTORY:     min_history     <= cfg_data[7:0];
        REG_DROP_FACTOR:     drop_factor     <= cfg_data[7:0];
        REG_SPIKE_THRESHOLD: spike_threshold <= cfg_data[14:0];
        REG_CLOSEST_GAP:     closest_gap     <= cfg_data;
        default: ;
      endcase
    end
  end

  // window state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr         <= '0;
      count       <= '0;
      sum         <= '0;
      ss          <= '0;
      fsl         <= '0;
      kfc         <= '0;
      drop_state  <= 1'b0;
      spike_state <= 1'b0;
      valid_r     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_word.func) begin
              fsl <= '0;
            end else begin
              s_reg <= in_word.surprise;
              if (kfc != 16'hffff) kfc <= kfc + 16'd1;
              if (fsl != 16'hffff) fsl <= fsl + 16'd1;
            end
          end
        end
        S_OLD: begin
          full_r <= full;
          prod   <= mul_p;
          sum    <= sum + SUM_W'(s_reg) - (full ? SUM_W'($signed(ram_rdata)) : '0);
          if (!full) count <= count + CNT_W'(1);
          ptr <= (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + PTR_W'(1);
        end
        S_NEW: begin
          if (full_r) ss <= ss - prod[SQ_W-1:0];
          prod <= mul_p;
        end
        S_ADD: begin
          ss          <= ss + prod[SQ_W-1:0];
          valid_r     <= 1'b0;
          mean_r      <= '0;
          stdv        <= '0;
          z_r         <= '0;
          drop_state  <= 1'b0;
          spike_state <= 1'b0;
        end
        S_M0: prod <= mul_p;
        S_M1: begin
          acc  <= prod[DVD_W-1:0];
          prod <= mul_p;
        end
        S_M2: begin
          acc  <= acc + (prod[DVD_W-1:0] << 32);
          prod <= mul_p;
        end
        S_M3: begin
          dvd  <= (acc > prod[DVD_W-1:0]) ? acc - prod[DVD_W-1:0] : '0;
          prod <= mul_p;
        end
        S_M4: begin
          dvs <= prod[DVS_W-1:0];
          // the variance fits the quotient bits, so the upper dividend bits
          // stay below the divisor and seed the remainder
          rem <= RW'(dvd[DVD_W-1:VAR_Q_BITS]);
          quo <= '0;
          idx <= IDX_W'(VAR_Q_BITS - 1);
        end
        S_VDIV: begin
          quo <= quo_next;
          if (idx == '0) begin
            // variance floored at one lsb
            var_r <= (quo_next == '0) ? QUO_W'(1) : quo_next;
            rem   <= '0;
            root  <= '0;
            idx   <= IDX_W'(SQRT_STEPS - 1);
          end else begin
            rem <= rem_next;
            idx <= idx - IDX_W'(1);
          end
        end
        S_SQRT: begin
          root <= root_next;
          if (idx == '0) begin
            stdv <= root_next;
            dvd  <= DVD_W'(asum);
            dvs  <= DVS_W'(count);
            rem  <= '0;
            quo  <= '0;
            idx  <= IDX_W'(SUM_W - 1);
          end else begin
            rem <= rem_next;
            idx <= idx - IDX_W'(1);
          end
        end
        S_MDIV: begin
          rem <= rem_next;
          quo <= quo_next;
          idx <= idx - IDX_W'(1);
          if (idx == '0) begin
            mean_r <= sum[SUM_W-1] ? -$signed(quo_next[15:0]) : $signed(quo_next[15:0]);
          end
        end
        S_ZSET: begin
          dz_neg <= dz[16];
          dvd    <= DVD_W'({dz_mag[15:0], 8'b0});
          dvs    <= DVS_W'(stdv);
          rem    <= '0;
          quo    <= '0;
          idx    <= IDX_W'(Z_DVD_BITS - 1);
        end
        S_ZDIV: begin
          rem <= rem_next;
          quo <= quo_next;
          idx <= idx - IDX_W'(1);
          if (idx == '0) begin
            if (dz_neg) begin
              z_r <= (quo_next > QUO_W'(32768)) ? Z_MIN : -$signed(quo_next[15:0]);
            end else begin
              z_r <= (quo_next > QUO_W'(32767)) ? Z_MAX : $signed(quo_next[15:0]);
            end
          end
        end
        S_D1: prod <= mul_p;
        S_D2: begin
          acc  <= prod[DVD_W-1:0];
          prod <= mul_p;
        end
        S_D3: begin
          valid_r     <= 1'b1;
          drop_state  <= ($signed(acc) < $signed(prod[DVD_W-1:0])) || (z_r < Z_DROP_LIMIT);
          spike_state <= ($signed(17'(z_r)) > $signed({2'b00, spike_threshold}));
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_word.search      <= search;
            out_word.drop_flag   <= drop_state;
            out_word.spike_flag  <= spike_state;
            out_word.window_mean <= mean_r;
            out_word.window_std  <= stdv;
            out_word.zscore      <= z_r;
            out_word.stats_valid <= valid_r;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/swat_checker.sv =====
// port level checks for the surprise window anomaly trigger, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module swat_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input swat_pkg::swat_in_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input swat_pkg::swat_out_t out_word
);
  logic stats_clear;

  assign stats_clear = (out_word.window_mean == 16'sd0) && (out_word.window_std == 16'd0) &&
                       (out_word.zscore == 16'sd0) && !out_word.drop_flag &&
                       !out_word.spike_flag;

  // a keyframe word keeps the block busy for at least the next cycle
  `SWAT_ASSERT(a_kf_busy, (in_valid && !in_stall && !in_word.func) |=> in_stall, "keyframe word not held off")

  // a loop event leaves the input free in the next cycle and gives no result
  `SWAT_ASSERT(a_loop_free, (in_valid && !in_stall && in_word.func) |=> !in_stall, "loop event stalled the input")

  // without enough history all statistics read as zero
  `SWAT_ASSERT(a_stats_zero, (out_valid && !out_word.stats_valid) |-> stats_clear, "statistics set without history")

  `SWAT_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_word)), "stalled result word changed")

  `SWAT_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result word after reset")
endmodule

bind surprise_window_anomaly_trigger swat_checker u_swat_checker (.*);
`default_nettype wire
